### hw/rtl/ents_pkg.sv
// package for the exp(-x) taylor series block
// widths, limits, sequencer states and small helpers; no dependencies
`timescale 1ns / 1ps
package ents_pkg;

  localparam int X_W    = 21;
  localparam int N_W    = 10;
  localparam int D_W    = 64;
  localparam int X_FRAC = 16;
  localparam int HALF_W = 32;

  localparam int MAX_TERMS_DEF = 1023;
  localparam int FRAC_BITS_DEF = 32;

  localparam logic [D_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [D_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ACC,
    ST_FIN,
    ST_RCP_WAIT,
    ST_DONE
  } ents_state_t;

  function automatic logic [D_W-1:0] mag_limit(input logic neg);
    mag_limit = neg ? NEG_LIMIT : POS_LIMIT;
  endfunction

  function automatic logic [D_W-1:0] to_bits(input logic neg, input logic [D_W-1:0] mag);
    to_bits = neg ? (~mag + 64'd1) : mag;
  endfunction

endpackage

### hw/rtl/ents_if.sv
// valid/ready channel interfaces for the input, result and config ports
// depends on ents_pkg
`timescale 1ns / 1ps
interface ents_in_if;
  import ents_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;
  logic        [N_W-1:0] term_count;
  modport source (output valid, x_value, term_count, input ready);
  modport sink   (input valid, x_value, term_count, output ready);
endinterface

interface ents_out_if;
  import ents_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [D_W-1:0] exp_result;
  logic                  overflow_flag;
  modport source (output valid, exp_result, overflow_flag, input ready);
  modport sink   (input valid, exp_result, overflow_flag, output ready);
endinterface

interface ents_cfg_if;
  logic valid;
  logic ready;
  logic method_select;
  modport source (output valid, method_select, input ready);
  modport sink   (input valid, method_select, output ready);
endinterface

### hw/rtl/exp_neg_taylor_series.sv
// exp(-x) by truncated taylor series, fixed point; top level with config and output register
// per term: multiply low and high halves, divide by the term index, accumulate; the reciprocal
// mode ends with one more divide; DVW = max(69, 2*FRAC_BITS+1) bits, the series stops early on
// zero/overflow; one item at a time, next item taken once the result is in the out register
// synchronous active-low reset clears the sequencer and output valid, method_select to 1
// depends on ents_pkg, ents_if, ents_core, ents_div
`timescale 1ns / 1ps
module exp_neg_taylor_series import ents_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ents_in_if.sink   in_ch,
  ents_out_if.source out_ch,
  ents_cfg_if.sink  cfg_ch
);
  logic           method_r;
  logic           out_valid_r, out_valid_nxt;
  logic [D_W-1:0] out_data_r, out_data_nxt;
  logic           out_flag_r, out_flag_nxt;
  logic           res_valid, res_take, res_flag;
  logic [D_W-1:0] res_value;

  ents_core #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .x_value       (in_ch.x_value),
    .term_count    (in_ch.term_count),
    .method_select (method_r),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_value     (res_value),
    .res_flag      (res_flag)
  );

  assign cfg_ch.ready = 1'b1;
  assign res_take     = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_flag_nxt  = out_flag_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_value;
      out_flag_nxt  = res_flag;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_flag_r <= out_flag_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      method_r    <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) method_r <= cfg_ch.method_select;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.exp_result    = out_data_r;
  assign out_ch.overflow_flag = out_flag_r;
endmodule

### hw/rtl/ents_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on ents_pkg
`timescale 1ns / 1ps
module ents_div import ents_pkg::*; #(
  parameter int DVW = 81
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);
  localparam int CNT_W = $clog2(DVW + 1);

  logic [DVW-1:0]   dvd_r, dvd_nxt;
  logic [DVW-1:0]   q_r, q_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     trial;
  logic             qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[DVW-1]};
    qbit    = (trial >= {1'b0, dsr_r});
    dvd_nxt = dvd_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(DVW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits
      rem_nxt = qbit ? D_W'(trial - {1'b0, dsr_r}) : trial[D_W-1:0];
      q_nxt   = {q_r[DVW-2:0], qbit};
      dvd_nxt = {dvd_r[DVW-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

### hw/rtl/ents_core.sv
// series sequencer: shared 32x21 multiplier, term and sum registers,
// drives the shared divider for term steps and the final reciprocal; depends on ents_pkg, ents_div
`timescale 1ns / 1ps
module ents_core import ents_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [X_W-1:0] x_value,
  input  logic        [N_W-1:0] term_count,
  input  logic                  method_select,
  output logic                  res_valid,
  input  logic                  res_take,
  output logic        [D_W-1:0] res_value,
  output logic                  res_flag
);
  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int PW  = D_W + X_W;
  localparam int SHW = PW - X_FRAC;
  localparam int RW  = 2 * FRAC_BITS + 1;
  localparam int DVW = (SHW > RW) ? SHW : RW;
  localparam int MPW = HALF_W + X_W;

  ents_state_t state_r, state_nxt;

  logic           xneg_r, xneg_nxt;
  logic [X_W-1:0] xmag_r, xmag_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic           alt_r, alt_nxt;
  logic           flag_r, flag_nxt;
  logic           tneg_r, tneg_nxt;
  logic [D_W-1:0] tmag_r, tmag_nxt;
  logic           sneg_r, sneg_nxt;
  logic [D_W-1:0] smag_r, smag_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [D_W-1:0] res_r, res_nxt;

  logic [HALF_W-1:0] mul_a;
  logic [MPW-1:0]    mul_p;
  logic              div_start;
  logic [DVW-1:0]    div_dvd;
  logic [D_W-1:0]    div_dsr;
  logic              div_done;
  logic [DVW-1:0]    div_q;

  logic           q_zero, nneg, term_ovf, rcp_ovf, sum_ovf, stop;
  logic [D_W:0]   sum_wide;

  ents_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mul_a = (state_r == ST_MUL_HI) ? tmag_r[D_W-1:HALF_W] : tmag_r[HALF_W-1:0];
  assign mul_p = MPW'(mul_a) * MPW'(xmag_r);

  always_comb begin
    q_zero   = (div_q == '0);
    nneg     = ((tneg_r != xneg_r) != alt_r) && !q_zero;
    term_ovf = (|div_q[DVW-1:D_W]) || (div_q[D_W-1:0] > mag_limit(nneg));
    rcp_ovf  = (|div_q[DVW-1:D_W]) || (div_q[D_W-1:0] > mag_limit(sneg_r));
    sum_wide = {1'b0, smag_r} + {1'b0, tmag_r};
    sum_ovf  = (sneg_r == tneg_r) && (sum_wide > {1'b0, mag_limit(sneg_r)});
    stop     = 1'b0;

    xneg_nxt = xneg_r;
    xmag_nxt = xmag_r;
    n_nxt    = n_r;
    i_nxt    = i_r;
    alt_nxt  = alt_r;
    flag_nxt = flag_r;
    tneg_nxt = tneg_r;
    tmag_nxt = tmag_r;
    sneg_nxt = sneg_r;
    smag_nxt = smag_r;
    prod_nxt = prod_r;
    res_nxt  = res_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          xneg_nxt = x_value[X_W-1];
          xmag_nxt = x_value[X_W-1] ? (~x_value + X_W'(1)) : x_value;
          if (32'(term_count) > MAX_TERMS) n_nxt = CW'(MAX_TERMS);
          else n_nxt = CW'(term_count);
          i_nxt    = CW'(1);
          alt_nxt  = !method_select;
          flag_nxt = 1'b0;
          tneg_nxt = 1'b0;
          sneg_nxt = 1'b0;
          tmag_nxt = D_W'(1) << FRAC_BITS;
          smag_nxt = D_W'(1) << FRAC_BITS;
        end
      end
      ST_MUL_LO: prod_nxt = PW'(mul_p);
      ST_MUL_HI: prod_nxt = prod_r + (PW'(mul_p) << HALF_W);
      ST_DIV_GO: ;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (term_ovf) begin
            flag_nxt = 1'b1;
            sneg_nxt = nneg;
            smag_nxt = mag_limit(nneg);
          end else begin
            tneg_nxt = nneg;
            tmag_nxt = div_q[D_W-1:0];
          end
        end
      end
      ST_ACC: begin
        stop = 1'b1;
        if (sum_ovf) begin
          flag_nxt = 1'b1;
          smag_nxt = mag_limit(sneg_r);
        end else begin
          if (sneg_r == tneg_r) begin
            smag_nxt = sum_wide[D_W-1:0];
          end else if (smag_r >= tmag_r) begin
            smag_nxt = smag_r - tmag_r;
          end else begin
            smag_nxt = tmag_r - smag_r;
            sneg_nxt = tneg_r;
          end
          if (smag_nxt == '0) sneg_nxt = 1'b0;
          stop  = (tmag_r == '0) || (i_r == n_r);
          i_nxt = i_r + CW'(1);
        end
      end
      ST_FIN: begin
        if (alt_r) begin
          res_nxt = to_bits(sneg_r, smag_r);
        end else if (smag_r == '0) begin
          flag_nxt = 1'b1;
          res_nxt  = POS_LIMIT;
        end
      end
      ST_RCP_WAIT: begin
        if (div_done) begin
          if (rcp_ovf) begin
            flag_nxt = 1'b1;
            res_nxt  = mag_limit(sneg_r);
          end else begin
            res_nxt = to_bits(sneg_r, div_q[D_W-1:0]);
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = (n_nxt == '0) ? ST_FIN : ST_MUL_LO;
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = term_ovf ? ST_FIN : ST_ACC;
      ST_ACC:      state_nxt = stop ? ST_FIN : ST_MUL_LO;
      ST_FIN:      state_nxt = (alt_r || smag_r == '0) ? ST_DONE : ST_RCP_WAIT;
      ST_RCP_WAIT: if (div_done) state_nxt = ST_DONE;
      ST_DONE:     if (res_take) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    div_start = (state_r == ST_DIV_GO) ||
                ((state_r == ST_FIN) && !alt_r && (smag_r != '0));
    div_dvd   = (state_r == ST_DIV_GO) ? DVW'(prod_r[PW-1:X_FRAC])
                                       : (DVW'(1) << (2 * FRAC_BITS));
    div_dsr   = (state_r == ST_DIV_GO) ? D_W'(i_r) : smag_r;
  end

  always_ff @(posedge clk) begin
    xneg_r <= xneg_nxt;
    xmag_r <= xmag_nxt;
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    alt_r  <= alt_nxt;
    flag_r <= flag_nxt;
    tneg_r <= tneg_nxt;
    tmag_r <= tmag_nxt;
    sneg_r <= sneg_nxt;
    smag_r <= smag_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign res_value = res_r;
  assign res_flag  = flag_r;
endmodule

### dv/ents_tb_if.sv
// testbench types for expected answers and table vectors
// the block's interfaces live in hw/rtl/ents_if.sv and depend on ents_pkg; this package depends on ents_pkg
`timescale 1ns / 1ps
package ents_tb_types;
  import ents_pkg::*;

  typedef struct packed {
    logic [D_W-1:0] exp_result;
    logic           overflow_flag;
  } exp_answer_t;

  typedef struct {
    logic signed [X_W-1:0] x_value;
    logic        [N_W-1:0] term_count;
    bit                    known;
    logic        [D_W-1:0] exp_result;
    logic                  overflow_flag;
  } exp_vector_t;
endpackage

### dv/testbench.sv
// self-checking bench for exp_neg_taylor_series: directed table, then random items per method
// predicts each result with its own bit-exact series model; depends on ents_pkg, ents_if, ents_tb_if
`timescale 1ns / 1ps
module testbench;
  import ents_pkg::*;
  import ents_tb_types::*;

  localparam logic [D_W-1:0] ONE_FIX = 64'd1 << FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 6000000;
  localparam int HOLD_CYCLES  = 20000;
  localparam logic METHOD_ALT = 1'b0;
  localparam logic METHOD_RCP = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ents_in_if  in_ch ();
  ents_out_if out_ch ();
  ents_cfg_if cfg_ch ();

  exp_neg_taylor_series i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #4 clk = ~clk;

  exp_answer_t pending_q[$];
  logic  method_now = METHOD_RCP;
  int    err_cnt = 0;
  int    items_sent = 0;
  int    results_seen = 0;
  int    flags_seen = 0;
  int    cycle_cnt = 0;
  bit    hold_done = 0;
  int    hold_cnt = 0;

  // truncating series model: term_i = s * term_(i-1) * x / i
  function automatic exp_answer_t series_exp(logic signed [X_W-1:0] x, logic [N_W-1:0] n,
                                             logic method);
    exp_answer_t r;
    logic [63:0]  xmag, tmag, smag, lim;
    logic [127:0] prod, quo;
    logic [64:0]  wsum;
    logic xneg, tneg, sneg, nneg, alt, flag;
    int cnt;
    xneg = x[X_W-1];
    xmag = xneg ? (64'd1 << X_W) - {43'd0, x} : {43'd0, x};
    alt = (method == METHOD_ALT);
    cnt = (n > MAX_TERMS_DEF) ? MAX_TERMS_DEF : n;
    tmag = ONE_FIX;
    smag = ONE_FIX;
    tneg = 0;
    sneg = 0;
    flag = 0;
    for (int i = 1; i <= cnt; i++) begin
      prod = ({64'd0, tmag} * {64'd0, xmag}) >> X_FRAC;
      quo = prod / 128'(i);
      nneg = (tneg != xneg) != alt;
      if (quo == 0) nneg = 0;
      lim = nneg ? NEG_LIMIT : POS_LIMIT;
      if (quo[127:64] != 0 || quo[63:0] > lim) begin
        flag = 1;
        sneg = nneg;
        smag = lim;
        break;
      end
      tneg = nneg;
      tmag = quo[63:0];
      if (sneg == tneg) begin
        wsum = {1'b0, smag} + {1'b0, tmag};
        lim = sneg ? NEG_LIMIT : POS_LIMIT;
        if (wsum > {1'b0, lim}) begin
          flag = 1;
          smag = lim;
          break;
        end
        smag = wsum[63:0];
      end else if (smag >= tmag) begin
        smag = smag - tmag;
      end else begin
        smag = tmag - smag;
        sneg = tneg;
      end
      if (smag == 0) sneg = 0;
      if (tmag == 0) break;
    end
    if (alt) begin
      r.exp_result = sneg ? -smag : smag;
    end else if (smag == 0) begin
      flag = 1;
      r.exp_result = POS_LIMIT;
    end else begin
      quo = (128'd1 << (2 * FRAC_BITS_DEF)) / {64'd0, smag};
      lim = sneg ? NEG_LIMIT : POS_LIMIT;
      if (quo[127:64] != 0 || quo[63:0] > lim) begin
        flag = 1;
        r.exp_result = lim;
      end else begin
        r.exp_result = sneg ? -quo[63:0] : quo[63:0];
      end
    end
    r.overflow_flag = flag;
    return r;
  endfunction

  task automatic send_item(logic signed [X_W-1:0] x, logic [N_W-1:0] n, bit known,
                           exp_answer_t typed, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.x_value    <= x;
    in_ch.term_count <= n;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.insert(pending_q.size(), known ? typed : series_exp(x, n, method_now));
    items_sent++;
  endtask

  task automatic write_method(logic m);
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (10) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.method_select <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    method_now = m;
  endtask

  task automatic run_table();
    exp_vector_t vec[16];
    exp_answer_t typed;
    vec = '{
      '{21'sd0,        10'd0,    1, ONE_FIX, 1'b0},  // n of zero leaves the constant one
      '{21'sd0,        10'd1023, 1, ONE_FIX, 1'b0},  // x of zero: first term vanishes
      '{21'sd65536,    10'd0,    1, ONE_FIX, 1'b0},
      '{-21'sd1048576, 10'd0,    1, ONE_FIX, 1'b0},
      '{21'sd1048575,  10'd1023, 0, '0, 1'b0},
      '{-21'sd1048576, 10'd1023, 0, '0, 1'b0},
      '{21'sd1048575,  10'd1,    0, '0, 1'b0},
      '{-21'sd1048576, 10'd1,    0, '0, 1'b0},
      '{21'sd1,        10'd1023, 0, '0, 1'b0},
      '{-21'sd1,       10'd1023, 0, '0, 1'b0},
      '{21'sd65536,    10'd1023, 0, '0, 1'b0},
      '{-21'sd65536,   10'd20,   0, '0, 1'b0},
      '{21'sd524288,   10'd5,    0, '0, 1'b0},
      '{-21'sd524288,  10'd512,  0, '0, 1'b0},
      '{21'sd32768,    10'd2,    0, '0, 1'b0},
      '{-21'sd699050,  10'd100,  0, '0, 1'b0}
    };
    foreach (vec[k]) begin
      typed.exp_result    = vec[k].exp_result;
      typed.overflow_flag = vec[k].overflow_flag;
      send_item(vec[k].x_value, vec[k].term_count, vec[k].known, typed, 1);
    end
  endtask

  task automatic run_random(int count);
    exp_answer_t none;
    logic [N_W-1:0] n;
    bit calm;
    none = '0;
    for (int k = 0; k < count; k++) begin
      n = ($urandom_range(0, 9) == 0) ? N_W'($urandom) : N_W'($urandom_range(0, 40));
      calm = (items_sent >= 130 && items_sent < 170);
      send_item(X_W'($urandom), n, 0, none, !calm);
    end
  endtask

  // result side: random stall, one long hold-off so the input backs up
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen == 30) begin
      hold_done    <= 1;
      hold_cnt     <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (results_seen >= 120 && results_seen < 160) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 12);
    end
  end

  always @(posedge clk) begin
    exp_answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.overflow_flag) flags_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", out_ch.exp_result);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.exp_result !== want.exp_result) begin
          $error("exp_result expected %h actual %h", want.exp_result, out_ch.exp_result);
          err_cnt++;
        end
        if (out_ch.overflow_flag !== want.overflow_flag) begin
          $error("overflow_flag expected %b actual %b", want.overflow_flag,
                 out_ch.overflow_flag);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.x_value        = '0;
    in_ch.term_count     = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.method_select = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_table();                 // reset value of the method: reciprocal
    write_method(METHOD_ALT);
    run_table();
    run_random(92);
    write_method(METHOD_RCP);
    run_random(92);
    write_method(METHOD_ALT);
    run_random(64);
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d items in both methods, %0d results checked, %0d with overflow flag",
             items_sent, results_seen, flags_seen);
    $display("covered table extremes, random x over all 21 bits and term counts up to 1023");
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
